/* rtl/esl_pkg.sv */
// Shared types, result codes and character helpers for the escaped string
// literal decoder. No dependencies; the apb, dec, out_buf and top use it.
`default_nettype none

package esl_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_SYNTAX = 2'd2;
    localparam logic [1:0] KIND_LONG   = 2'd3;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG1   = 8'h31;
    localparam logic [7:0] CH_DIG2   = 8'h32;
    localparam logic [7:0] CH_DIG3   = 8'h33;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ESC    = 8'h1B;

    // Address decode of the configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned CAP_W   = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic       last;
    } t_result;

    // Up to two results produced by one input character.
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_pair;

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_DIG0) && (c < 8'h38);
    endfunction

    // Simple one-character escapes; returns {valid, byte}.
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] v;
        case (c)
            8'h61:     v = {1'b1, 8'h07};
            8'h62:     v = {1'b1, 8'h08};
            8'h65:     v = {1'b1, CH_ESC};
            8'h66:     v = {1'b1, 8'h0C};
            8'h6E:     v = {1'b1, 8'h0A};
            8'h72:     v = {1'b1, 8'h0D};
            8'h74:     v = {1'b1, 8'h09};
            8'h76:     v = {1'b1, 8'h0B};
            CH_QMARK:  v = {1'b1, c};
            CH_BSLASH: v = {1'b1, c};
            CH_SQUOTE: v = {1'b1, c};
            CH_QUOTE:  v = {1'b1, c};
            default:   v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic t_result mk_res(input logic [7:0] b, input logic [1:0] k);
        t_result r;
        r.data_byte = b;
        r.kind      = k;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/esld_ifs.sv */
// Valid/ready channel interfaces for the character input and result output.
// Depends on nothing but the handshake convention valid && ready.
`default_nettype none

interface esld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface esld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output data_byte, output kind, output last, input ready);
    modport sink (input valid, input data_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

/* rtl/esld_apb.sv */
// Configuration register block: capacity register on an APB-style port.
// Uses esl_pkg for widths and reset value; outputs the clamped capacity.
`default_nettype none

module esld_apb
    import esl_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output logic [CAP_W-1:0]        o_cap_eff
);

    localparam logic [CAP_W-1:0] CAP_LIM =
        (MAX_CAPACITY > 511) ? 9'd511 : CAP_W'(MAX_CAPACITY);

    logic [CAP_W-1:0] r_cap;
    logic             sel_cap;

    assign sel_cap = (paddr[PADDR_W-1] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = sel_cap ? {23'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && sel_cap) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // Zero behaves as one, values above the build limit as the limit.
    always_comb begin
        if (r_cap == '0) begin
            o_cap_eff = 9'd1;
        end else if (r_cap > CAP_LIM) begin
            o_cap_eff = CAP_LIM;
        end else begin
            o_cap_eff = r_cap;
        end
    end

endmodule

`default_nettype wire

/* rtl/esld_in_stage.sv */
// Input register for the character channel.
// Uses esld_in_if; releases the held character when the decoder advances.
`default_nettype none

module esld_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    esld_in_if.sink    i_in,
    input  wire logic  i_adv,
    output logic       o_valid,
    output logic [7:0] o_ch
);

    logic       r_valid;
    logic [7:0] r_ch;

    assign i_in.ready = !r_valid || i_adv;
    assign o_valid    = r_valid;
    assign o_ch       = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch <= i_in.ch;
        end
    end

endmodule

`default_nettype wire

/* rtl/esld_dec.sv */
// Literal decoder state and next-state logic: phase, partial escape value
// and stored byte count. Uses esl_pkg; yields up to two results per character.
`default_nettype none

module esld_dec
    import esl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic [7:0]       i_ch,
    input  wire logic [CAP_W-1:0] i_cap,
    output t_pair                 o_pair
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LIT  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_ZERO = 3'd5,
        PH_OCT2 = 3'd6,
        PH_OCT3 = 3'd7
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_part, n_part;
    logic [CAP_W-1:0] r_cnt, n_cnt;

    logic             st0, chain, fin;
    logic [7:0]       st0_byte;
    logic [4:0]       hv;
    logic [8:0]       em;
    logic             oct;
    logic [2:0]       dig;
    logic [CAP_W-1:0] cnt1;
    t_result          res0, res1;
    logic [1:0]       num;

    // True when one more stored byte still leaves room for the terminator.
    function automatic logic cap_ok(input logic [CAP_W-1:0] cnt, input logic [CAP_W-1:0] cap);
        return ({1'b0, cnt} + 10'd1) < {1'b0, cap};
    endfunction

    assign hv   = hex_val(i_ch);
    assign em   = esc_map(i_ch);
    assign oct  = is_oct(i_ch);
    assign dig  = i_ch[2:0];
    assign cnt1 = r_cnt + 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_part   = r_part;
        n_cnt    = r_cnt;
        st0      = 1'b0;
        st0_byte = 8'd0;
        chain    = 1'b0;
        fin      = 1'b0;
        res0     = '0;
        res1     = '0;
        num      = 2'd0;

        case (r_phase)
            PH_IDLE: begin
                if (i_ch == CH_QUOTE) begin
                    n_cnt   = '0;
                    n_part  = 8'd0;
                    n_phase = PH_LIT;
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
            PH_LIT: begin
                if (i_ch == CH_QUOTE) begin
                    res0 = mk_res(8'd0, KIND_OK);
                    num  = 2'd1;
                    fin  = 1'b1;
                end else if (i_ch == CH_NUL) begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end else if (i_ch == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    st0      = 1'b1;
                    st0_byte = i_ch;
                end
            end
            PH_ESC: begin
                if (em[8]) begin
                    st0      = 1'b1;
                    st0_byte = em[7:0];
                end else if (i_ch == CH_X) begin
                    n_phase = PH_HEX1;
                end else if (i_ch == CH_DIG0) begin
                    n_phase = PH_ZERO;
                    n_part  = 8'd0;
                end else if (i_ch == CH_DIG1 || i_ch == CH_DIG2 || i_ch == CH_DIG3) begin
                    n_part  = {dig[1:0], 6'd0};
                    n_phase = PH_OCT2;
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
            PH_HEX1: begin
                if (hv[4]) begin
                    n_part  = {hv[3:0], 4'd0};
                    n_phase = PH_HEX2;
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
            PH_HEX2: begin
                if (hv[4]) begin
                    st0      = 1'b1;
                    st0_byte = r_part + {4'd0, hv[3:0]};
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
            PH_ZERO: begin
                if (oct) begin
                    n_part  = {2'd0, dig, 3'd0};
                    n_phase = PH_OCT3;
                end else begin
                    // A lone zero escape stores NUL, then the character
                    // is taken again as in the literal phase.
                    st0      = 1'b1;
                    st0_byte = 8'd0;
                    chain    = 1'b1;
                end
            end
            PH_OCT2: begin
                if (oct) begin
                    n_part  = r_part + {2'd0, dig, 3'd0};
                    n_phase = PH_OCT3;
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
            default: begin
                if (oct) begin
                    st0      = 1'b1;
                    st0_byte = r_part + {5'd0, dig};
                end else begin
                    res0 = mk_res(8'd0, KIND_SYNTAX);
                    num  = 2'd1;
                    fin  = 1'b1;
                end
            end
        endcase

        if (st0) begin
            if (cap_ok(r_cnt, i_cap)) begin
                res0    = mk_res(st0_byte, KIND_BYTE);
                num     = 2'd1;
                n_cnt   = cnt1;
                n_part  = 8'd0;
                n_phase = PH_LIT;
                if (chain) begin
                    if (i_ch == CH_QUOTE) begin
                        res1 = mk_res(8'd0, KIND_OK);
                        num  = 2'd2;
                        fin  = 1'b1;
                    end else if (i_ch == CH_NUL) begin
                        res1 = mk_res(8'd0, KIND_SYNTAX);
                        num  = 2'd2;
                        fin  = 1'b1;
                    end else if (i_ch == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else if (cap_ok(cnt1, i_cap)) begin
                        res1  = mk_res(i_ch, KIND_BYTE);
                        num   = 2'd2;
                        n_cnt = cnt1 + 9'd1;
                    end else begin
                        res1 = mk_res(8'd0, KIND_LONG);
                        num  = 2'd2;
                        fin  = 1'b1;
                    end
                end
            end else begin
                // The byte that reaches capacity is withheld.
                res0 = mk_res(8'd0, KIND_LONG);
                num  = 2'd1;
                fin  = 1'b1;
            end
        end

        if (fin) begin
            n_phase = PH_IDLE;
            n_part  = 8'd0;
            n_cnt   = '0;
        end

        if (num == 2'd1) begin
            res0.last = 1'b1;
        end
        if (num == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign o_pair.num = num;
    assign o_pair.r0  = res0;
    assign o_pair.r1  = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_part  <= 8'd0;
            r_cnt   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_part  <= n_part;
            r_cnt   <= n_cnt;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0 && r_part == 8'd0))
        else $error("idle phase with leftover count or partial value");

    // A stored byte that does not also end the literal leaves a nonzero count.
    a_cnt_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && num != 2'd0 && (res0.kind == KIND_BYTE) && !fin) |=>
            (r_cnt != '0))
        else $error("stored byte did not advance the count");

endmodule

`default_nettype wire

/* rtl/esld_out_buf.sv */
// Two-slot result register: holds the results of one character and
// presents them in order on the output channel. Uses esl_pkg and esld_out_if.
`default_nettype none

module esld_out_buf
    import esl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_pair i_pair,
    output logic       o_adv,
    esld_out_if.source o_out
);

    logic [1:0] r_cnt;
    t_result    r_s0, r_s1;
    logic       pop;

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.data_byte = r_s0.data_byte;
    assign o_out.kind      = r_s0.kind;
    assign o_out.last      = r_s0.last;

    assign pop   = o_out.valid && o_out.ready;
    // A held character advances if the buffer is empty or drains this cycle.
    assign o_adv = i_in_valid && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (o_adv) begin
            r_cnt <= i_pair.num;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s0 <= i_pair.r0;
            r_s1 <= i_pair.r1;
        end else if (pop) begin
            r_s0 <= r_s1;
        end
    end

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_s0.last && r_s1.last))
        else $error("two held results with wrong last marking");

    a_non_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_BYTE) |-> (o_out.data_byte == 8'd0))
        else $error("end result carries a nonzero data byte");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("result buffer count out of range");

endmodule

`default_nettype wire

/* rtl/escaped_string_literal_decoder.sv */
// Escaped string literal decoder, top level.
// Instantiates esld_apb, esld_in_stage, esld_dec and esld_out_buf; uses esl_pkg.
//
// Usage:
//   i_in carries one raw character per request (valid/ready). The block waits
//   for an opening quote, then returns one decoded byte per plain character or
//   completed escape on o_out, and ends the literal with closed ok, syntax
//   error or too long. A lone zero escape followed by a non-backslash
//   character can yield two results for one request; last marks the final
//   result of a request. An accepted character passes the input register and
//   the output register. Throughput: one character per cycle while o_out.ready
//   is high, bounded by one result per cycle through the two-slot register.
//   Stalls: when o_out.ready is low the results stay held, the input register
//   keeps one more character, and then i_in.ready drops until the output drains.
//   Reset (synchronous, active low): capacity returns to 256, the decoder waits
//   for an opening quote and the channels are empty. No clearing pass is needed.
//   Configuration: capacity at byte address 0, written while the block is idle.
`default_nettype none

module escaped_string_literal_decoder
    import esl_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    esld_in_if.sink                 i_in,
    esld_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [CAP_W-1:0] cap_eff;
    logic             adv;
    logic             ch_valid;
    logic [7:0]       ch;
    t_pair            pair;

    esld_apb #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cap_eff (cap_eff)
    );

    esld_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (ch_valid),
        .o_ch    (ch)
    );

    esld_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ch    (ch),
        .i_cap   (cap_eff),
        .o_pair  (pair)
    );

    esld_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (ch_valid),
        .i_pair     (pair),
        .o_adv      (adv),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
